@@ design/smf_pkg.sv @@
package smf_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned POS_W    = 11;
  localparam int unsigned TEXT_MAX = 1024;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_NEW  = 2'd0,
    FUNC_APP  = 2'd1,
    FUNC_TEXT = 2'd2
  } func_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_MATCH     = 2'd0,
    KIND_END_NONE  = 2'd1,
    KIND_END_FOUND = 2'd2
  } kind_e;

  typedef struct packed {
    logic pat_new;
    logic pat_app;
    logic txt_step;
    logic srch_clr;
  } cmd_t;

  typedef struct packed {
    logic hit;
  } sts_t;

endpackage

@@ design/smf_ctrl.sv @@
module smf_ctrl
  import smf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [FUNC_W-1:0] func_i,
  input  logic              eot_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [KIND_W-1:0] kind_o,
  output logic              last_o,
  output cmd_t              cmd_o,
  input  sts_t              sts_i
);

  typedef enum logic {
    ST_NONE,
    ST_FOUND
  } state_e;

  state_e            state_q;
  logic              out_valid_q;
  logic [KIND_W-1:0] kind_q;
  logic              last_q;
  logic              accept;
  logic              is_text;
  logic              emit;
  kind_e             kind_d;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o = '0;
    case (func_i)
      FUNC_NEW:  cmd_o.pat_new  = accept;
      FUNC_APP:  cmd_o.pat_app  = accept;
      FUNC_TEXT: cmd_o.txt_step = accept;
      default:   cmd_o = '0;
    endcase
    is_text        = cmd_o.txt_step;
    cmd_o.srch_clr = cmd_o.pat_new || cmd_o.pat_app || (is_text && eot_i);
    emit           = is_text && (sts_i.hit || eot_i);
    if (sts_i.hit) begin
      kind_d = KIND_MATCH;
    end else if (state_q == ST_FOUND) begin
      kind_d = KIND_END_FOUND;
    end else begin
      kind_d = KIND_END_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_NONE;
      out_valid_q <= 1'b0;
      kind_q      <= KIND_END_NONE;
      last_q      <= 1'b0;
    end else begin
      if (cmd_o.srch_clr) begin
        state_q <= ST_NONE;
      end else if (is_text && sts_i.hit) begin
        state_q <= ST_FOUND;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
        kind_q      <= kind_d;
        last_q      <= eot_i;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign last_o      = last_q;

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (kind_q != KIND_MATCH) |-> last_q)
    else $error("end record without last");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !in_ready_o)
    else $error("request taken while result stalled");

  a_found_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && eot_i |=> state_q == ST_NONE)
    else $error("found flag survives end of search");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (kind_q == KIND_MATCH || kind_q == KIND_END_NONE ||
                     kind_q == KIND_END_FOUND))
    else $error("illegal result kind");

endmodule

@@ design/smf_datapath.sv @@
module smf_datapath
  import smf_pkg::*;
#(
  parameter int unsigned PAT_MAX  = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  input  logic [BYTE_W-1:0] byte_i,
  output sts_t              sts_o,
  output logic [POS_W-1:0]  pos_o
);

  localparam int unsigned LW = $clog2(PAT_MAX + 1);
  localparam int unsigned CW = $clog2(TEXT_MAX + 1);
  localparam int unsigned PW = ((CW > LW) ? CW : LW) + 1;

  logic [BYTE_W-1:0] pat_q [PAT_MAX];
  logic [LW-1:0]     len_q;
  logic [PAT_MAX-1:0] act_q, act_d, eq, tail;
  logic [CW-1:0]     cnt_q;
  logic [POS_W-1:0]  pos_q;
  logic              room;
  logic              upd;
  logic              hit;
  logic [PW-1:0]     pos_w;

  // one compare cell per pattern byte, prefix-match chain across cells
  for (genvar i = 0; i < PAT_MAX; i++) begin : g_cell
    assign eq[i]   = (pat_q[i] == byte_i);
    assign tail[i] = (LW'(i + 1) == len_q);
    if (i == 0) begin : g_first
      assign act_d[i] = eq[i];
    end else begin : g_rest
      assign act_d[i] = act_q[i-1] && eq[i];
    end

    always_ff @(posedge clk_i) begin
      if ((cmd_i.pat_new && i == 0) ||
          (cmd_i.pat_app && (LW'(i) == len_q))) begin
        pat_q[i] <= byte_i;
      end
    end
  end

  assign room  = (cnt_q < CW'(TEXT_MAX));
  assign upd   = cmd_i.txt_step && room;
  assign hit   = upd && (len_q != '0) && (|(act_d & tail));
  assign pos_w = PW'(cnt_q) + PW'(2) - PW'(len_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      act_q <= '0;
      cnt_q <= '0;
    end else begin
      if (cmd_i.pat_new) begin
        len_q <= LW'(1);
      end else if (cmd_i.pat_app && (len_q < LW'(PAT_MAX))) begin
        len_q <= len_q + LW'(1);
      end
      if (cmd_i.srch_clr) begin
        act_q <= '0;
        cnt_q <= '0;
      end else if (upd) begin
        act_q <= act_d;
        cnt_q <= cnt_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.txt_step) begin
      pos_q <= hit ? POS_W'(pos_w) : '0;
    end
  end

  assign sts_o.hit = hit;
  assign pos_o     = pos_q;

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LW'(PAT_MAX))
    else $error("pattern length beyond store");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(TEXT_MAX))
    else $error("text count beyond limit");

  a_act_needs_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (|act_q) |-> (cnt_q != '0))
    else $error("partial match with no text");

endmodule

@@ design/substring_match_finder_core.sv @@
// Naive substring search over a byte stream. Pattern bytes come first on the
// slave side (tuser 0 starts a new pattern, 1 appends a byte), then text bytes
// (tuser 2) with tlast on the final one. Each text byte that completes a match
// gives a result with the 1-based start position; the final byte gives an end
// record (kind 1 no match, 2 after matches) unless it matched itself. A row of
// per-byte compare cells tracks every partial match at once, so one request is
// taken each cycle; any result is registered and shows in the cycle after, and the
// single output register holds off the input only while a result waits.
module substring_match_finder_core
  import smf_pkg::*;
#(
  parameter int unsigned PAT_MAX  = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] func
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [10:0] position, [15:11] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast
);

  cmd_t             cmd;
  sts_t             sts;
  logic [POS_W-1:0] pos;

  smf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .func_i      (s_axis_tuser),
    .eot_i       (s_axis_tlast),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .kind_o      (m_axis_tuser),
    .last_o      (m_axis_tlast),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  smf_datapath #(
    .PAT_MAX  (PAT_MAX)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .byte_i (s_axis_tdata),
    .sts_o  (sts),
    .pos_o  (pos)
  );

  assign m_axis_tdata = 16'(pos);

endmodule
